// ===== design/fgre_pkg.sv =====
// ----------------------------------------------------------------------------
// fgre_pkg: shared types and codes of the frame geometry remap engine
// Register indexes, mode codes, the configuration record and the status
// record that the fetch sequencer hands to the top level.
// ----------------------------------------------------------------------------
package fgre_pkg;

	// Width of one stored BGR pixel.
	localparam int PIX_W = 24;

	// Operation codes of an input item.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Transform modes; codes 6 and 7 behave as a horizontal flip.
	localparam logic [2:0] MODE_FLIP_H = 3'd0;
	localparam logic [2:0] MODE_FLIP_V = 3'd1;
	localparam logic [2:0] MODE_ROT_R  = 3'd2;
	localparam logic [2:0] MODE_ROT_L  = 3'd3;
	localparam logic [2:0] MODE_CROP   = 3'd4;
	localparam logic [2:0] MODE_SCALE  = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_SRC_WIDTH  = 3'd1;
	localparam logic [2:0] REG_SRC_HEIGHT = 3'd2;
	localparam logic [2:0] REG_WIN_X      = 3'd3;
	localparam logic [2:0] REG_WIN_Y      = 3'd4;
	localparam logic [2:0] REG_OUT_WIDTH  = 3'd5;
	localparam logic [2:0] REG_OUT_HEIGHT = 3'd6;

	// Raw configuration register contents.
	typedef struct packed {
		logic [2:0] mode;
		logic [8:0] src_width;
		logic [8:0] src_height;
		logic [7:0] win_x;
		logic [7:0] win_y;
		logic [8:0] out_width;
		logic [8:0] out_height;
	} cfg_t;

	// Status of a finished fetch, valid for one cycle.
	typedef struct packed {
		logic valid;
		logic last;
		logic err;
	} fetch_res_t;

	// Fetch sequencer states.
	typedef enum logic [2:0] {
		FS_IDLE,
		FS_COORD,
		FS_DIV,
		FS_LIN,
		FS_RED,
		FS_ADDR,
		FS_READ,
		FS_RESULT
	} fetch_state_t;

endpackage

// ===== design/fgre_store.sv =====
// ----------------------------------------------------------------------------
// fgre_store: frame store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module fgre_store #(
	parameter int MAX_PIXELS = 65536,
	localparam int AW = $clog2(MAX_PIXELS)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [fgre_pkg::PIX_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [fgre_pkg::PIX_W-1:0] rd_data
);

	logic [fgre_pkg::PIX_W-1:0] mem [MAX_PIXELS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/fgre_div.sv =====
// ----------------------------------------------------------------------------
// fgre_div: iterative divider for the scale source index
// Restoring division that produces one quotient bit per cycle. The caller
// guarantees that the quotient fits in CW bits and the divisor is nonzero.
// ----------------------------------------------------------------------------
module fgre_div #(
	parameter int MAX_DIM = 256,
	localparam int DIM_W = $clog2(MAX_DIM + 1),
	localparam int CW = $clog2(MAX_DIM),
	localparam int VW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VW-1:0]    num,
	input  logic [DIM_W-1:0] den,
	output logic             done,
	output logic [CW-1:0]    quo
);

	localparam int DVW = DIM_W + CW;
	localparam int SW = (CW > 1) ? $clog2(CW) : 1;

	logic           run_q;
	logic           done_q;
	logic [SW-1:0]  step_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] ds_q;
	logic [CW-1:0]  quo_q;
	logic           ge;

	assign ge = (rem_q >= ds_q);

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= SW'(CW - 1);
		end else begin
			done_q <= run_q && (step_q == '0);
			if (run_q) begin
				if (step_q == '0) begin
					run_q <= 1'b0;
				end else begin
					step_q <= step_q - SW'(1);
				end
			end
		end
	end

	// Partial remainder, shifted divisor and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DVW'(num);
			ds_q  <= DVW'(den) << (CW - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - ds_q;
			end
			ds_q  <= ds_q >> 1;
			quo_q <= CW'({quo_q, ge});
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== design/fgre_fetch.sv =====
// ----------------------------------------------------------------------------
// fgre_fetch: fetch sequencer
// Walks the output raster, maps each output pixel to a source coordinate,
// turns it into a frame store address and issues the read.
// ----------------------------------------------------------------------------
module fgre_fetch #(
	parameter int MAX_DIM = 256,
	parameter int MAX_PIXELS = 65536,
	localparam int DIM_W = $clog2(MAX_DIM + 1),
	localparam int AW = $clog2(MAX_PIXELS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  fgre_pkg::cfg_t         cfg,
	input  logic [DIM_W-1:0]       src_w,
	input  logic [DIM_W-1:0]       src_h,
	output logic                   busy,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	output fgre_pkg::fetch_res_t   res
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int VW = $clog2(MAX_DIM * MAX_DIM);
	localparam int XW = ((DIM_W > 9) ? DIM_W : 9) + 1;
	localparam int PRW = CW + DIM_W;
	localparam int L = $clog2(MAX_PIXELS);
	localparam int K = VW + L;
	localparam int RW = VW + 2;
	localparam int PW = VW + RW;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << K) + 64'(MAX_PIXELS) - 64'd1) / 64'(MAX_PIXELS);
	localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

	fgre_pkg::fetch_state_t state_q, state_d;

	logic [CW-1:0]    row_q, col_q;
	logic [CW-1:0]    r_q, c_q;
	logic [DIM_W-1:0] ow_q, oh_q;
	logic             err_q;
	logic [CW-1:0]    sx_q, sy_q;
	logic [VW-1:0]    lin_q;
	logic [VW-1:0]    qm_q;
	logic [AW-1:0]    addr_q;

	logic [XW-1:0] w_x, h_x, ow_x, oh_x, ow_cl, oh_cl;
	logic [XW-1:0] r_x, c_x, sx_x, sy_x;
	logic          geo_ok, restart;
	logic          col_end, row_end;
	logic          div_start, div_done_c, div_done_r;
	logic [CW-1:0] quo_c, quo_r;
	logic [VW-1:0] num_c, num_r;
	logic [PRW-1:0] prod_c, prod_r, lin_v;
	logic [PW-1:0] recip_prod, recip_shift;
	logic [VW-1:0] addr_v;

	// Output size and window check for the item being accepted.
	always_comb begin
		w_x   = XW'(src_w);
		h_x   = XW'(src_h);
		ow_cl = (XW'(cfg.out_width) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(cfg.out_width);
		oh_cl = (XW'(cfg.out_height) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(cfg.out_height);
		case (cfg.mode)
			fgre_pkg::MODE_ROT_R, fgre_pkg::MODE_ROT_L: begin
				ow_x   = h_x;
				oh_x   = w_x;
				geo_ok = 1'b1;
			end
			fgre_pkg::MODE_CROP: begin
				ow_x   = XW'(cfg.out_width);
				oh_x   = XW'(cfg.out_height);
				geo_ok = (ow_x != '0) && (oh_x != '0) &&
					(XW'(cfg.win_x) + ow_x <= w_x) &&
					(XW'(cfg.win_y) + oh_x <= h_x);
			end
			fgre_pkg::MODE_SCALE: begin
				ow_x   = ow_cl;
				oh_x   = oh_cl;
				geo_ok = (ow_x != '0) && (oh_x != '0);
			end
			default: begin
				ow_x   = w_x;
				oh_x   = h_x;
				geo_ok = 1'b1;
			end
		endcase
		restart = (XW'(row_q) >= oh_x) || (XW'(col_q) >= ow_x);
	end

	// Source coordinate for every mode except scale.
	always_comb begin
		r_x = XW'(r_q);
		c_x = XW'(c_q);
		case (cfg.mode)
			fgre_pkg::MODE_FLIP_V: begin
				sx_x = c_x;
				sy_x = h_x - XW'(1) - r_x;
			end
			fgre_pkg::MODE_ROT_R: begin
				sx_x = w_x - XW'(1) - r_x;
				sy_x = c_x;
			end
			fgre_pkg::MODE_ROT_L: begin
				sx_x = r_x;
				sy_x = h_x - XW'(1) - c_x;
			end
			fgre_pkg::MODE_CROP: begin
				sx_x = XW'(cfg.win_x) + c_x;
				sy_x = (h_x + r_x) - (XW'(cfg.win_y) + XW'(oh_q));
			end
			fgre_pkg::MODE_SCALE: begin
				sx_x = '0;
				sy_x = '0;
			end
			default: begin
				sx_x = w_x - XW'(1) - c_x;
				sy_x = r_x;
			end
		endcase
	end

	// Scale numerators feed the dividers, which register them at start.
	assign prod_c    = PRW'(c_q) * PRW'(src_w);
	assign prod_r    = PRW'(r_q) * PRW'(src_h);
	assign num_c     = VW'(prod_c);
	assign num_r     = VW'(prod_r);
	assign div_start = (state_q == fgre_pkg::FS_COORD) && (cfg.mode == fgre_pkg::MODE_SCALE);

	fgre_div #(.MAX_DIM(MAX_DIM)) u_div_col (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_c),
		.den    (ow_q),
		.done   (div_done_c),
		.quo    (quo_c)
	);

	fgre_div #(.MAX_DIM(MAX_DIM)) u_div_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_r),
		.den    (oh_q),
		.done   (div_done_r),
		.quo    (quo_r)
	);

	// Linear index, then its reduction modulo the store depth by reciprocal.
	assign lin_v       = PRW'(sy_q) * PRW'(src_w) + PRW'(sx_q);
	assign recip_prod  = PW'(lin_q) * PW'(RECIP);
	assign recip_shift = recip_prod >> K;
	assign addr_v      = lin_q - (qm_q * VW'(MAX_PIXELS));

	// End of row and last row for the current pixel.
	assign col_end = (XW'(c_q) + XW'(1) >= XW'(ow_q));
	assign row_end = (XW'(r_q) + XW'(1) >= XW'(oh_q));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fgre_pkg::FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs.
	always_comb begin
		state_d   = state_q;
		busy      = (state_q != fgre_pkg::FS_IDLE);
		rd_en     = 1'b0;
		rd_addr   = addr_q;
		res.valid = 1'b0;
		res.err   = err_q;
		res.last  = err_q || (col_end && row_end);
		case (state_q)
			fgre_pkg::FS_IDLE: begin
				if (go) begin
					state_d = geo_ok ? fgre_pkg::FS_COORD : fgre_pkg::FS_RESULT;
				end
			end
			fgre_pkg::FS_COORD: begin
				state_d = (cfg.mode == fgre_pkg::MODE_SCALE) ?
					fgre_pkg::FS_DIV : fgre_pkg::FS_LIN;
			end
			fgre_pkg::FS_DIV: begin
				if (div_done_c && div_done_r) begin
					state_d = fgre_pkg::FS_LIN;
				end
			end
			fgre_pkg::FS_LIN: begin
				state_d = fgre_pkg::FS_RED;
			end
			fgre_pkg::FS_RED: begin
				state_d = fgre_pkg::FS_ADDR;
			end
			fgre_pkg::FS_ADDR: begin
				state_d = fgre_pkg::FS_READ;
			end
			fgre_pkg::FS_READ: begin
				rd_en   = 1'b1;
				state_d = fgre_pkg::FS_RESULT;
			end
			fgre_pkg::FS_RESULT: begin
				res.valid = 1'b1;
				state_d   = fgre_pkg::FS_IDLE;
			end
			default: begin
				state_d = fgre_pkg::FS_IDLE;
			end
		endcase
	end

	// Output raster position, advanced when a result leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (state_q == fgre_pkg::FS_RESULT) begin
			if (err_q) begin
				row_q <= '0;
				col_q <= '0;
			end else if (!col_end) begin
				row_q <= r_q;
				col_q <= c_q + CW'(1);
			end else if (!row_end) begin
				row_q <= r_q + CW'(1);
				col_q <= '0;
			end else begin
				row_q <= '0;
				col_q <= '0;
			end
		end
	end

	// Per item datapath registers.
	always_ff @(posedge clk) begin
		if ((state_q == fgre_pkg::FS_IDLE) && go) begin
			ow_q  <= DIM_W'(ow_x);
			oh_q  <= DIM_W'(oh_x);
			err_q <= !geo_ok;
			r_q   <= restart ? '0 : row_q;
			c_q   <= restart ? '0 : col_q;
		end
		if (state_q == fgre_pkg::FS_COORD) begin
			sx_q <= CW'(sx_x);
			sy_q <= CW'(sy_x);
		end
		if ((state_q == fgre_pkg::FS_DIV) && div_done_c) begin
			sx_q <= quo_c;
			sy_q <= quo_r;
		end
		if (state_q == fgre_pkg::FS_LIN) begin
			lin_q <= VW'(lin_v);
		end
		if (state_q == fgre_pkg::FS_RED) begin
			qm_q <= VW'(recip_shift);
		end
		if (state_q == fgre_pkg::FS_ADDR) begin
			addr_q <= AW'(addr_v);
		end
	end

endmodule

// ===== design/frame_geometry_remap_engine.sv =====
// ----------------------------------------------------------------------------
// frame_geometry_remap_engine: frame store with flip, rotate, crop and scale
// Loads a BGR frame into a frame store and reads it back transformed.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge where start is high and busy is low.
//   operation selects a load (store one pixel, bottom row first) or a fetch
//   (return the next pixel of the transformed frame).
//   A load leaves busy low, so loads can stream at one pixel per cycle while
//   no fetch is in flight. A load produces no result.
//   A fetch raises busy. Its result is marked by done for exactly one cycle,
//   with the pixel ports and flags registered alongside. For scale, the
//   source coordinate waits on the two index dividers (one quotient bit per
//   cycle); an invalid window skips the address pipeline and goes straight
//   to the result.
//   A new item is taken in the cycle the result is shown. Every valid fetch
//   passes through the address pipeline: coordinate, linear index, modulo
//   reduction, address register, and the registered store read.
//   The receiver cannot stall; each result is a one-cycle transfer.
//   Configuration is written through cfg_we, cfg_index and cfg_data while
//   no fetch is in flight. Reset clears the registers to their defaults and
//   the load and output counters to zero; the frame store is not cleared.
// ----------------------------------------------------------------------------
module frame_geometry_remap_engine #(
	parameter int MAX_DIM = 256,
	parameter int MAX_PIXELS = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       operation,
	input  logic [7:0] in_blue,
	input  logic [7:0] in_green,
	input  logic [7:0] in_red,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data,
	output logic       done,
	output logic [7:0] out_blue,
	output logic [7:0] out_green,
	output logic [7:0] out_red,
	output logic       last_pixel,
	output logic       param_error
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int VW = $clog2(MAX_DIM * MAX_DIM);
	localparam int NPW = 2 * DIM_W;
	localparam int AW = $clog2(MAX_PIXELS);

	fgre_pkg::cfg_t       cfg_q;
	fgre_pkg::fetch_res_t fres;

	logic [DIM_W-1:0] w_c, h_c;
	logic [NPW-1:0]   npix, nli;
	logic [VW-1:0]    ld_index_q, li;
	logic [AW-1:0]    ld_addr_q, wa;
	logic             beyond, ld_wrap;
	logic             load_go, fetch_go, fetch_busy;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [fgre_pkg::PIX_W-1:0] rd_data;

	logic       done_q, last_q, err_q;
	logic [7:0] blue_q, green_q, red_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= fgre_pkg::MODE_FLIP_H;
			cfg_q.src_width  <= 9'd1;
			cfg_q.src_height <= 9'd1;
			cfg_q.win_x      <= 8'd0;
			cfg_q.win_y      <= 8'd0;
			cfg_q.out_width  <= 9'd1;
			cfg_q.out_height <= 9'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				fgre_pkg::REG_MODE:       cfg_q.mode       <= cfg_data[2:0];
				fgre_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data;
				fgre_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data;
				fgre_pkg::REG_WIN_X:      cfg_q.win_x      <= cfg_data[7:0];
				fgre_pkg::REG_WIN_Y:      cfg_q.win_y      <= cfg_data[7:0];
				fgre_pkg::REG_OUT_WIDTH:  cfg_q.out_width  <= cfg_data;
				fgre_pkg::REG_OUT_HEIGHT: cfg_q.out_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// Source size with zero read as one and large values held at the limit.
	always_comb begin
		if (cfg_q.src_width == '0) begin
			w_c = DIM_W'(1);
		end else if (32'(cfg_q.src_width) > 32'(MAX_DIM)) begin
			w_c = DIM_W'(MAX_DIM);
		end else begin
			w_c = DIM_W'(cfg_q.src_width);
		end
		if (cfg_q.src_height == '0) begin
			h_c = DIM_W'(1);
		end else if (32'(cfg_q.src_height) > 32'(MAX_DIM)) begin
			h_c = DIM_W'(MAX_DIM);
		end else begin
			h_c = DIM_W'(cfg_q.src_height);
		end
	end

	// Item acceptance.
	assign busy     = fetch_busy;
	assign load_go  = start && !fetch_busy && (operation == fgre_pkg::OP_LOAD);
	assign fetch_go = start && !fetch_busy && (operation == fgre_pkg::OP_FETCH);

	// Load position; the store address follows it modulo the store depth.
	assign npix    = NPW'(w_c) * NPW'(h_c);
	assign beyond  = (NPW'(ld_index_q) >= npix);
	assign li      = beyond ? '0 : ld_index_q;
	assign wa      = beyond ? '0 : ld_addr_q;
	assign nli     = NPW'(li) + NPW'(1);
	assign ld_wrap = (nli >= npix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_index_q <= '0;
			ld_addr_q  <= '0;
		end else if (load_go) begin
			if (ld_wrap) begin
				ld_index_q <= '0;
				ld_addr_q  <= '0;
			end else begin
				ld_index_q <= VW'(nli);
				ld_addr_q  <= (wa == AW'(MAX_PIXELS - 1)) ? '0 : wa + AW'(1);
			end
		end
	end

	fgre_store #(.MAX_PIXELS(MAX_PIXELS)) u_store (
		.clk     (clk),
		.wr_en   (load_go),
		.wr_addr (wa),
		.wr_data ({in_red, in_green, in_blue}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fgre_fetch #(.MAX_DIM(MAX_DIM), .MAX_PIXELS(MAX_PIXELS)) u_fetch (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (fetch_go),
		.cfg     (cfg_q),
		.src_w   (w_c),
		.src_h   (h_c),
		.busy    (fetch_busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.res     (fres)
	);

	// Result strobe and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			last_q <= 1'b0;
			err_q  <= 1'b0;
		end else begin
			done_q <= fres.valid;
			if (fres.valid) begin
				last_q <= fres.last;
				err_q  <= fres.err;
			end
		end
	end

	// Result pixel; an error result carries black.
	always_ff @(posedge clk) begin
		if (fres.valid) begin
			blue_q  <= fres.err ? 8'd0 : rd_data[7:0];
			green_q <= fres.err ? 8'd0 : rd_data[15:8];
			red_q   <= fres.err ? 8'd0 : rd_data[23:16];
		end
	end

	assign done        = done_q;
	assign out_blue    = blue_q;
	assign out_green   = green_q;
	assign out_red     = red_q;
	assign last_pixel  = last_q;
	assign param_error = err_q;

	// Each fetch is accepted in idle and its result leaves from a later state, so results never abut.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// An accepted fetch holds off further items in the next cycle.
	a_fetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == fgre_pkg::OP_FETCH)) |=> busy)
		else $error("fetch accepted without raising busy");

	// An error result ends the frame and carries black.
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && param_error) |-> (last_pixel && (out_blue == 8'd0) &&
			(out_green == 8'd0) && (out_red == 8'd0)))
		else $error("error result with last mark clear or nonzero color");

	// The store is read only while a fetch is in progress.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (fetch_busy && !load_go))
		else $error("store read outside a fetch");

endmodule
